// ===== hw/rtl/expm1_negative_half_float_unit_macros.svh =====
`ifndef EXPM1_NEGATIVE_HALF_FLOAT_UNIT_MACROS_SVH
`define EXPM1_NEGATIVE_HALF_FLOAT_UNIT_MACROS_SVH

// same-cycle implication, checked while out of reset
`define EXPM1H_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define EXPM1H_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/expm1h_pkg.sv =====
`timescale 1ns / 1ps

package expm1h_pkg;

    // pipeline depth from input register to output register
    localparam int DEPTH = 13;

    // half-precision codes
    localparam logic [14:0] HALF_INF_MAG    = 15'h7C00;
    localparam logic [14:0] HALF_CUTOFF_MAG = 15'h4829;
    localparam logic [14:0] HALF_ONE_MAG    = 15'h3C00;
    localparam logic [15:0] HALF_NEG_ONE    = 16'hBC00;
    localparam logic [15:0] HALF_POS_ZERO   = 16'h0000;

    // coefficients at 2^-40 scale
    localparam logic [63:0] Q40_LOG2E = 64'h1715476 << 16;
    localparam logic [63:0] Q40_LN2   = 64'h162E43 << 19;
    localparam logic [63:0] Q40_C2    = 64'h1FFFAEE << 14;
    localparam logic [63:0] Q40_C1    = 64'h1028C1C << 16;

    typedef struct packed {
        logic ood;
        logic last;
    } t_side;

endpackage

// ===== hw/rtl/expm1h_mul.sv =====
`timescale 1ns / 1ps

module expm1h_mul #(
    parameter int A_W = 32,
    parameter int B_W = 33
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [A_W-1:0]       i_a,
    input  logic [B_W-1:0]       i_b,
    output logic [A_W+B_W-1:0]   o_p
);

    localparam int LO_W = (B_W + 1) / 2;
    localparam int HI_W = B_W - LO_W;
    localparam int P_W  = A_W + B_W;

    logic [A_W+LO_W-1:0] r_pl;
    logic [A_W+HI_W-1:0] r_ph;
    logic [P_W-1:0]      r_p;

    // two half-width partial products, then one add
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pl <= i_a * i_b[LO_W-1:0];
            r_ph <= i_a * i_b[B_W-1:LO_W];
            r_p  <= (P_W'(r_ph) << LO_W) + P_W'(r_pl);
        end
    end

    assign o_p = r_p;

endmodule

// ===== hw/rtl/expm1_negative_half_float_unit.sv =====
// expm1 of a negative half value, fixed-point pipeline.
// Throughput: one request per cycle; all stages advance together and hold while
// the output register is full and stalled, so o_stall follows i_stall there.
// Reset (synchronous, active low) clears the stage valid bits only.
`timescale 1ns / 1ps

module expm1_negative_half_float_unit #(
    parameter int FRAC_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_x_bits,
    input  logic        i_is_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_y_bits,
    output logic        o_out_of_domain,
    output logic        o_last_out
);

    localparam int F      = FRAC_BITS;
    localparam int D      = expm1h_pkg::DEPTH;
    localparam int SA_W   = $clog2(F);
    localparam int MW     = F + 3;
    localparam int H_W    = $clog2(F + 3);
    localparam int MIN_SH = F - 24;
    localparam int SH40   = 40 - F;

    localparam logic [63:0] LOG2E_64 =
        (expm1h_pkg::Q40_LOG2E + ((64'd1 << SH40) >> 1)) >> SH40;
    localparam logic [63:0] LN2_64 =
        (expm1h_pkg::Q40_LN2 + ((64'd1 << SH40) >> 1)) >> SH40;
    localparam logic [63:0] C2_64 =
        (expm1h_pkg::Q40_C2 + ((64'd1 << SH40) >> 1)) >> SH40;
    localparam logic [63:0] C1_64 =
        (expm1h_pkg::Q40_C1 + ((64'd1 << SH40) >> 1)) >> SH40;

    localparam logic [F:0]   LOG2E_F = LOG2E_64[F:0];
    localparam logic [F-1:0] LN2_F   = LN2_64[F-1:0];
    localparam logic [F-1:0] C2_F    = C2_64[F-1:0];
    localparam logic [F:0]   C1_F    = C1_64[F:0];

    logic w_adv;
    logic [D:1] r_vld;
    expm1h_pkg::t_side r_side [1:D];

    // stage registers
    logic [10:0]     r1_m;
    logic [SA_W-1:0] r1_sa;
    logic [F+11:0]   r1_pm;
    logic [F+3:0]    r2_xmag;
    logic [F+5:0]    r2_vmag;
    logic [F+3:0]    r3_xmag;
    logic [4:0]      r_k [3:10];
    logic [F+1:0]    r4_t;
    logic            r_tneg [5:10];
    logic [F-1:0]    r5_tmag;
    logic [F-1:0]    r_tsmag [5:8];
    logic [F:0]      r8_p;
    logic [F+2:0]    r11_f;
    logic [MW-1:0]   r12_mag;
    logic [H_W-1:0]  r12_h;
    logic            r12_neg;
    logic [15:0]     r13_y;

    assign w_adv   = !(r_vld[D] && i_stall);
    assign o_stall = !w_adv;

    // decode and clamp
    logic [14:0] w_mb;
    logic        w_ood;
    logic [4:0]  w_e;
    logic [10:0] w_m;

    always_comb begin
        w_ood = 1'b0;
        priority if (i_x_bits[14:0] > expm1h_pkg::HALF_INF_MAG) begin
            w_ood = 1'b1;
            w_mb  = expm1h_pkg::HALF_CUTOFF_MAG;
        end else if (!i_x_bits[15]) begin
            w_ood = (i_x_bits[14:0] != 15'd0);
            w_mb  = 15'd0;
        end else if (i_x_bits[14:0] > expm1h_pkg::HALF_CUTOFF_MAG) begin
            w_mb  = expm1h_pkg::HALF_CUTOFF_MAG;
        end else begin
            w_mb  = i_x_bits[14:0];
        end
        if (w_mb[14:10] != 5'd0) begin
            w_e = w_mb[14:10];
            w_m = {1'b1, w_mb[9:0]};
        end else begin
            w_e = 5'd1;
            w_m = {1'b0, w_mb[9:0]};
        end
    end

    // stage 2: align x and round x*log2e
    logic [2*F+4:0] w_vfull;
    logic [2*F+5:0] w_vsum;
    assign w_vfull = (2*F+5)'(r1_pm) << r1_sa;
    assign w_vsum  = {1'b0, w_vfull} + ((2*F+6)'(1) << (F - 1));

    // stage 3: n = floor(v + 1/2), k = -n clamped to 0..20
    logic [F+6:0] w_w;
    logic [6:0]   w_nn;
    logic [7:0]   w_k8;
    logic [4:0]   w_k;
    assign w_w  = ((F+7)'(1) << (F - 1)) - {1'b0, r2_vmag};
    assign w_nn = w_w[F+6:F];
    assign w_k8 = 8'd0 - {w_nn[6], w_nn};

    always_comb begin
        priority if (!w_nn[6]) begin
            w_k = 5'd0;
        end else if (w_k8 > 8'd20) begin
            w_k = 5'd20;
        end else begin
            w_k = w_k8[4:0];
        end
    end

    // stage 4: t = x + k*ln2
    logic [F+4:0] w_kl;
    logic [F+5:0] w_tfull;
    assign w_kl    = r_k[3] * LN2_F;
    assign w_tfull = {1'b0, w_kl} - {2'b00, r3_xmag};

    // stage 5: magnitude of t and t*2^n
    logic         w_tneg;
    logic [F+1:0] w_tabs;
    logic [F-1:0] w_tmag;
    logic [F:0]   w_tssum;
    logic [F:0]   w_tsshift;
    assign w_tneg    = r4_t[F+1];
    assign w_tabs    = w_tneg ? (F+2)'(0) - r4_t : r4_t;
    assign w_tmag    = w_tabs[F-1:0];
    assign w_tssum   = {1'b0, w_tmag} + (((F+1)'(1) << r_k[4]) >> 1);
    assign w_tsshift = w_tssum >> r_k[4];

    // stages 6-7: c2*|t|
    logic [2*F-1:0] w_proda;
    expm1h_mul #(
        .A_W (F),
        .B_W (F)
    ) u_mul_p (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_a   (r5_tmag),
        .i_b   (C2_F),
        .o_p   (w_proda)
    );

    // stage 8: p = c1 + c2*t
    logic [2*F:0] w_ra_sum;
    logic [F:0]   w_ra;
    logic [F+1:0] w_p_full;
    assign w_ra_sum = {1'b0, w_proda} + ((2*F+1)'(1) << (F - 1));
    assign w_ra     = w_ra_sum[2*F:F];
    assign w_p_full = r_tneg[7] ? {1'b0, C1_F} - {1'b0, w_ra} : {1'b0, C1_F} + {1'b0, w_ra};

    // stages 9-10: |t*s|*p
    logic [2*F:0] w_prodb;
    expm1h_mul #(
        .A_W (F),
        .B_W (F + 1)
    ) u_mul_f (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_a   (r_tsmag[8]),
        .i_b   (r8_p),
        .o_p   (w_prodb)
    );

    // stage 11: f = (s - 1) + (t*s)*p
    logic [2*F+1:0] w_rb_sum;
    logic [F+1:0]   w_rb;
    logic [F:0]     w_s1;
    logic [F+2:0]   w_f;
    assign w_rb_sum = {1'b0, w_prodb} + ((2*F+2)'(1) << (F - 1));
    assign w_rb     = w_rb_sum[2*F+1:F];
    assign w_s1     = ((F+1)'(1) << F) - ((F+1)'(1) << (F - int'(r_k[10])));
    assign w_f      = (r_tneg[10] ? (F+3)'(0) - (F+3)'(w_rb) : (F+3)'(w_rb)) - (F+3)'(w_s1);

    // stage 12: magnitude and leading one
    logic           w_fneg;
    logic [MW-1:0]  w_fmag;
    logic [H_W-1:0] w_h;
    assign w_fneg = r11_f[F+2];
    assign w_fmag = w_fneg ? MW'(0) - r11_f : r11_f;

    always_comb begin
        w_h = '0;
        for (int i = 0; i < MW; i++) begin
            if (w_fmag[i]) begin
                w_h = H_W'(i);
            end
        end
    end

    // stage 13: round to nearest even and pack
    logic [H_W-1:0] w_sh;
    logic [MW-1:0]  w_qt;
    logic [MW-1:0]  w_low;
    logic [MW-1:0]  w_half;
    logic           w_rnd;
    logic [11:0]    w_q;
    logic [4:0]     w_ex;
    logic [17:0]    w_bits;
    logic           w_sat;
    logic [15:0]    w_y;

    assign w_sh   = (int'(r12_h) - 10 > MIN_SH) ? H_W'(int'(r12_h) - 10) : H_W'(MIN_SH);
    assign w_qt   = r12_mag >> w_sh;
    assign w_low  = r12_mag & ((MW'(1) << w_sh) - MW'(1));
    assign w_half = (MW'(1) << w_sh) >> 1;
    assign w_rnd  = (w_sh != '0) && ((w_low > w_half) || ((w_low == w_half) && w_qt[0]));
    assign w_q    = w_qt[11:0] + 12'(w_rnd);
    assign w_ex   = 5'(int'(w_sh) - MIN_SH);
    assign w_bits = ({13'd0, w_ex} << 10) + {6'd0, w_q};
    assign w_sat  = w_bits > {3'd0, expm1h_pkg::HALF_INF_MAG};
    assign w_y    = (r12_mag == '0) ? expm1h_pkg::HALF_POS_ZERO :
                    {r12_neg, w_sat ? expm1h_pkg::HALF_INF_MAG : w_bits[14:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[D-1:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side[1] <= '{ood: w_ood, last: i_is_last};
            for (int i = 2; i <= D; i++) begin
                r_side[i] <= r_side[i-1];
            end
            r1_m    <= w_m;
            r1_sa   <= SA_W'(int'(w_e) + F - 25);
            r1_pm   <= w_m * LOG2E_F;
            r2_xmag <= (F+4)'(r1_m) << r1_sa;
            r2_vmag <= w_vsum[2*F+5:F];
            r3_xmag <= r2_xmag;
            r_k[3]  <= w_k;
            for (int i = 4; i <= 10; i++) begin
                r_k[i] <= r_k[i-1];
            end
            r4_t        <= w_tfull[F+1:0];
            r_tneg[5]   <= w_tneg;
            for (int i = 6; i <= 10; i++) begin
                r_tneg[i] <= r_tneg[i-1];
            end
            r5_tmag     <= w_tmag;
            r_tsmag[5]  <= w_tsshift[F-1:0];
            for (int i = 6; i <= 8; i++) begin
                r_tsmag[i] <= r_tsmag[i-1];
            end
            r8_p    <= w_p_full[F:0];
            r11_f   <= w_f;
            r12_mag <= w_fmag;
            r12_h   <= w_h;
            r12_neg <= w_fneg;
            r13_y   <= w_y;
        end
    end

    assign o_valid         = r_vld[D];
    assign o_y_bits        = r13_y;
    assign o_out_of_domain = r_side[D].ood;
    assign o_last_out      = r_side[D].last;

endmodule

// ===== hw/rtl/expm1h_check.sv =====
`timescale 1ns / 1ps
`include "expm1_negative_half_float_unit_macros.svh"

module expm1h_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_y_bits,
    input logic        o_out_of_domain,
    input logic        o_last_out
);

    // hold a stalled result
    `EXPM1H_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_y_bits) && $stable(o_out_of_domain) && $stable(o_last_out),
        "stalled result changed")

    // push back on the input only while the output is held
    `EXPM1H_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall,
        "input stalled without a held result")

    // results lie in [-1, 0]
    `EXPM1H_ASSERT_NOW(a_range, i_clk, i_rst_n, o_valid,
        (o_y_bits == expm1h_pkg::HALF_POS_ZERO) ||
        (o_y_bits[15] && (o_y_bits[14:0] <= expm1h_pkg::HALF_ONE_MAG)),
        "result outside [-1, 0]")

    // a clamped request gives +0 or -1
    `EXPM1H_ASSERT_NOW(a_clamp_value, i_clk, i_rst_n, o_valid && o_out_of_domain,
        (o_y_bits == expm1h_pkg::HALF_POS_ZERO) || (o_y_bits == expm1h_pkg::HALF_NEG_ONE),
        "clamped request gave other value")

endmodule

bind expm1_negative_half_float_unit expm1h_check u_expm1h_check (.*);
